/* sv/tsin_pkg.sv */
// tsin_pkg: shared widths, constants and controller/datapath interface structs
// for the Taylor series sine block. No dependencies.
`default_nettype none

package tsin_pkg;

    // Field widths
    localparam int ANGLE_W = 32;
    localparam int SINE_W  = 32;
    localparam int THR_W   = 31;
    localparam logic [THR_W-1:0] THR_RESET = 31'd11;   // ~1e-8 in Q2.30

    localparam int FRAC_BITS = 30;

    // Datapath widths
    localparam int M_W     = 32;      // term magnitude, at most 2^31
    localparam int SQ_W    = 33;      // x^2, at most 2^32
    localparam int MUL_B_W = 17;      // multiplier chunk width
    localparam int PROD_W  = M_W + MUL_B_W;
    localparam int ACC_W   = 64;
    localparam int T_W     = ACC_W - FRAC_BITS;  // rounded product, 34 bits
    localparam int SUM_W   = 35;

    // Divider: radix 16, four quotient bits per cycle
    localparam int DIV_BITS   = 4;
    localparam int DIVD_W     = 36;
    localparam int DIV_STEPS  = DIVD_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Controller -> datapath commands
    typedef struct packed {
        logic load;      // capture angle, reset series state
        logic mul_sq;    // multiplier squares the angle (else term * x^2)
        logic mul_lo;    // low chunk product into accumulator
        logic mul_hi;    // high chunk product added into accumulator
        logic rnd_sq;    // round accumulator into x^2
        logic add_term;  // add signed term into running sum
        logic div_load;  // round accumulator into divider
        logic div_step;  // one radix-16 divide step
        logic div_last;  // qualifies div_step: final step, update term
        logic out_load;  // saturate sum into output register
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic stop;      // term below threshold or term budget used
        logic out_free;  // output register can take a result
    } t_dp_stat;

endpackage

`default_nettype wire

/* sv/taylor_series_sine.sv */
// taylor_series_sine: top level of the fixed-point Maclaurin series sine.
// Depends on tsin_pkg, tsin_ctrl and tsin_dp.
//
// Takes one angle in signed Q2.30 radians and returns its sine in signed
// Q2.30, summing x - x^3/3! + x^5/5! - ... until a term magnitude drops below
// the threshold register or MAX_TERMS terms have been added; the sum is
// saturated to the 32-bit range. One transaction is processed at a time:
// after acceptance, x^2 is formed by two multiplier passes and a rounding
// step; each summed term then takes a sign/threshold test, two passes
// through the shared 32x17 multiplier, a rounding step and the radix-16
// divider by (k+1)(k+2); a final test plus output load end the transaction.
// At most 8 terms are summed at the reset threshold, and never more than
// MAX_TERMS (12). The divider sets the per-term cost.
// The result sits in an output register, so the next angle can be taken
// while the previous sine still waits under stall. The threshold
// (31-bit unsigned Q1.30, reset 11) is written through i_cfg_wr_en/i_cfg_wr_data and
// should only change while no transaction is in flight.
`default_nettype none

module taylor_series_sine #(
    parameter int MAX_TERMS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tsin_pkg::ANGLE_W-1:0]  i_angle,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tsin_pkg::SINE_W-1:0]   o_sine,
    // threshold register write
    input  logic                          i_cfg_wr_en,
    input  logic [tsin_pkg::THR_W-1:0]    i_cfg_wr_data
);

    tsin_pkg::t_dp_cmd  w_cmd;
    tsin_pkg::t_dp_stat w_stat;

    // sequencer: one state per datapath operation
    tsin_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    // arithmetic, threshold and output register
    tsin_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_angle       (i_angle),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_sine        (o_sine)
    );

`ifndef SYNTHESIS
    // an accepted angle keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted but block not busy next cycle");

    // a result appears only from an output load command
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.out_load))
        else $error("output valid rose without a load");

    // never overwrite a result still waiting under stall
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_valid || !i_stall))
        else $error("output overwritten while stalled");

    // at most one datapath operation per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.mul_lo, w_cmd.mul_hi, w_cmd.rnd_sq,
                  w_cmd.add_term, w_cmd.div_load, w_cmd.div_step, w_cmd.out_load}))
        else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

/* sv/tsin_ctrl.sv */
// tsin_ctrl: sequencing state machine for the Taylor series sine block.
// Depends on tsin_pkg (command/status structs, divider step count).
`default_nettype none

module tsin_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output tsin_pkg::t_dp_cmd o_cmd,
    input  tsin_pkg::t_dp_stat i_stat
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SQ_LO  = 10'b00_0000_0010,
        S_SQ_HI  = 10'b00_0000_0100,
        S_SQ_RND = 10'b00_0000_1000,
        S_TEST   = 10'b00_0001_0000,
        S_MUL_LO = 10'b00_0010_0000,
        S_MUL_HI = 10'b00_0100_0000,
        S_RND    = 10'b00_1000_0000,
        S_DIV    = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [tsin_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic w_div_last;

    assign w_div_last = (r_div_cnt == tsin_pkg::DIV_CNT_W'(tsin_pkg::DIV_STEPS - 1));
    assign o_stall    = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQ_LO;
                end
            end
            S_SQ_LO: begin
                o_cmd.mul_sq = 1'b1;
                o_cmd.mul_lo = 1'b1;
                n_state      = S_SQ_HI;
            end
            S_SQ_HI: begin
                o_cmd.mul_sq = 1'b1;
                o_cmd.mul_hi = 1'b1;
                n_state      = S_SQ_RND;
            end
            S_SQ_RND: begin
                o_cmd.rnd_sq = 1'b1;
                n_state      = S_TEST;
            end
            S_TEST: begin
                if (i_stat.stop) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.add_term = 1'b1;
                    n_state        = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_RND;
            end
            S_RND: begin
                o_cmd.div_load = 1'b1;
                n_div_cnt      = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_last = w_div_last;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (w_div_last) begin
                    n_state = S_TEST;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

endmodule

`default_nettype wire

/* sv/tsin_dp.sv */
// tsin_dp: datapath for the Taylor series sine block: threshold register,
// shared 32x17 multiplier, radix-16 divider, running sum and output register.
// Depends on tsin_pkg.
`default_nettype none

module tsin_dp #(
    parameter int MAX_TERMS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsin_pkg::t_dp_cmd             i_cmd,
    output tsin_pkg::t_dp_stat            o_stat,
    input  logic [tsin_pkg::ANGLE_W-1:0]  i_angle,
    input  logic                          i_cfg_wr_en,
    input  logic [tsin_pkg::THR_W-1:0]    i_cfg_wr_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [tsin_pkg::SINE_W-1:0]   o_sine
);

    // k runs up to 2*MAX_TERMS+1; D = (k+1)(k+2) must fit 2*K_W bits
    localparam int K_W   = $clog2(2 * MAX_TERMS + 4);
    localparam int D_W   = 2 * K_W;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    localparam int M_W    = tsin_pkg::M_W;
    localparam int SQ_W   = tsin_pkg::SQ_W;
    localparam int B_W    = tsin_pkg::MUL_B_W;
    localparam int PROD_W = tsin_pkg::PROD_W;
    localparam int ACC_W  = tsin_pkg::ACC_W;
    localparam int T_W    = tsin_pkg::T_W;
    localparam int DIVD_W = tsin_pkg::DIVD_W;
    localparam int DIV_B  = tsin_pkg::DIV_BITS;
    localparam int SUM_W  = tsin_pkg::SUM_W;
    localparam int FRAC   = tsin_pkg::FRAC_BITS;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

    logic [tsin_pkg::THR_W-1:0] r_thr;
    logic [M_W-1:0]             r_a;
    logic [M_W-1:0]             r_m;
    logic [SQ_W-1:0]            r_sq;
    logic [K_W-1:0]             r_k;
    logic [D_W-1:0]             r_den;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_term_neg;
    logic signed [SUM_W-1:0]    r_sum;
    logic [ACC_W-1:0]           r_acc;
    logic [DIVD_W-1:0]          r_div;
    logic [D_W-1:0]             r_rem;
    logic                       r_out_valid;
    logic [tsin_pkg::SINE_W-1:0] r_sine;

    logic [M_W-1:0]    w_mag;
    logic [M_W-1:0]    w_op_a;
    logic [B_W-1:0]    w_op_b;
    logic [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]  w_rnd_const;
    logic [ACC_W-1:0]  w_rnd;
    logic [T_W-1:0]    w_t;
    logic [DIVD_W-1:0] n_div;
    logic [D_W-1:0]    n_rem;
    logic signed [SUM_W-1:0] w_m_s;
    logic [tsin_pkg::SINE_W-1:0] w_sat;

    // |angle|; -2.0 maps to 2^31 exactly
    assign w_mag = i_angle[tsin_pkg::ANGLE_W-1] ? (~i_angle + 1'b1) : i_angle;

    // Shared multiplier: 32 x 17, two passes per product
    always_comb begin
        if (i_cmd.mul_sq) begin
            w_op_a = r_a;
            w_op_b = i_cmd.mul_hi ? B_W'(r_a[M_W-1:B_W]) : r_a[B_W-1:0];
        end else begin
            w_op_a = r_m;
            w_op_b = i_cmd.mul_hi ? B_W'(r_sq[SQ_W-1:B_W]) : r_sq[B_W-1:0];
        end
    end

    assign w_prod = PROD_W'(w_op_a) * PROD_W'(w_op_b);

    // Round to nearest, ties up: (acc + D*2^29) >> 30, then divide by D (D = 1 for x^2)
    assign w_rnd_const = i_cmd.rnd_sq ? (ACC_W'(1) << (FRAC - 1))
                                      : (ACC_W'(r_den) << (FRAC - 1));
    assign w_rnd = r_acc + w_rnd_const;
    assign w_t   = w_rnd[ACC_W-1:FRAC];

    // Four restoring steps per cycle; remainder stays below D
    always_comb begin
        logic [D_W:0] rem2;
        logic [D_W-1:0] rem;
        logic [DIV_B-1:0] qbits;
        rem   = r_rem;
        qbits = '0;
        rem2  = '0;
        for (int i = 0; i < DIV_B; i++) begin
            rem2 = {rem, r_div[DIVD_W-1-i]};
            if (rem2 >= {1'b0, r_den}) begin
                rem2 = rem2 - {1'b0, r_den};
                qbits[DIV_B-1-i] = 1'b1;
            end
            rem = rem2[D_W-1:0];
        end
        n_rem = rem;
        n_div = {r_div[DIVD_W-DIV_B-1:0], qbits};
    end

    assign w_m_s = SUM_W'(r_m);

    always_comb begin
        if (r_sum > SAT_MAX) begin
            w_sat = {1'b0, {(tsin_pkg::SINE_W-1){1'b1}}};
        end else if (r_sum < SAT_MIN) begin
            w_sat = {1'b1, {(tsin_pkg::SINE_W-1){1'b0}}};
        end else begin
            w_sat = r_sum[tsin_pkg::SINE_W-1:0];
        end
    end

    assign o_stat.stop     = (r_cnt == CNT_W'(MAX_TERMS)) || (r_m < M_W'(r_thr));
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_sine          = r_sine;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= tsin_pkg::THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a        <= w_mag;
            r_m        <= w_mag;
            r_k        <= K_W'(1);
            r_den      <= D_W'(6);
            r_cnt      <= '0;
            r_sum      <= '0;
            r_term_neg <= i_angle[tsin_pkg::ANGLE_W-1];
        end
        if (i_cmd.mul_lo) begin
            r_acc <= ACC_W'(w_prod);
        end
        if (i_cmd.mul_hi) begin
            r_acc <= r_acc + (ACC_W'(w_prod) << B_W);
        end
        if (i_cmd.rnd_sq) begin
            r_sq <= w_t[SQ_W-1:0];
        end
        if (i_cmd.add_term) begin
            r_sum      <= r_term_neg ? (r_sum - w_m_s) : (r_sum + w_m_s);
            r_term_neg <= !r_term_neg;
            r_cnt      <= r_cnt + 1'b1;
        end
        if (i_cmd.div_load) begin
            r_div <= DIVD_W'(w_t);
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_div <= n_div;
            r_rem <= n_rem;
            if (i_cmd.div_last) begin
                r_m   <= n_div[M_W-1:0];
                r_k   <= r_k + K_W'(2);
                // (k+3)(k+4) - (k+1)(k+2) = 4k + 10
                r_den <= r_den + (D_W'(r_k) << 2) + D_W'(10);
            end
        end
        if (i_cmd.out_load) begin
            r_sine <= w_sat;
        end
    end

endmodule

`default_nettype wire
